[design/calibrated_sample_filter_top_assert.svh]
// Assertion macros shared by the checker of calibrated_sample_filter_top.
`ifndef CALIBRATED_SAMPLE_FILTER_TOP_ASSERT_SVH
`define CALIBRATED_SAMPLE_FILTER_TOP_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define CSF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CSF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/cfs_pkg.sv]
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types, codes and constants of the calibrated sample filter.
// ----------------------------------------------------------------------------
package cfs_pkg;

	localparam int CFG_W        = 16;
	localparam int IDX_W        = 2;
	localparam int WIN_LEN_W    = 5;
	localparam int STAMP_W      = 32;
	localparam int WINDOW_MAX_D = 16;
	localparam int SAMPLE_W_D   = 16;
	localparam int LP_ALPHA     = 51;
	localparam int LP_KEEP      = 205;
	localparam int SCALE_RST    = 256;
	localparam int WIN_LEN_RST  = 16;

	typedef enum logic [IDX_W-1:0] {
		CFG_OFFSET = 2'd0,
		CFG_SCALE  = 2'd1,
		CFG_MODE   = 2'd2,
		CFG_WINDOW = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_AVG  = 2'd1,
		MODE_MED  = 2'd2,
		MODE_LP   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_SUM,
		OP_CAND,
		OP_COUNT,
		OP_CHECK
	} rd_op_t;

	typedef struct packed {
		logic   take;
		logic   calc;
		logic   sat;
		logic   pass;
		logic   lp;
		logic   push;
		logic   sum_clr;
		rd_op_t op;
		logic   div_start;
		logic   div_step;
		logic   div_fix;
		logic   load_out;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  out_free;
	} status_t;

endpackage

[design/cfs_datapath.sv]
// ----------------------------------------------------------------------------
// cfs_datapath
// Configuration registers, calibration, window store, accumulator, divider,
// median counters, low-pass update and the result register.
// ----------------------------------------------------------------------------
module cfs_datapath import cfs_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_D,
	parameter int SAMPLE_W   = SAMPLE_W_D,
	localparam int SLOT_W    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
	localparam int CNT_W     = $clog2(WINDOW_MAX + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic [IDX_W-1:0]           cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic signed [SAMPLE_W-1:0] raw_sample,
	input  cmd_t                       cmd,
	input  logic [SLOT_W-1:0]          rd_addr,
	input  logic                       result_stall,
	output status_t                    status,
	output logic [CNT_W-1:0]           fill,
	output logic                       result_valid,
	output logic signed [SAMPLE_W-1:0] filtered_value,
	output logic [STAMP_W-1:0]         sample_stamp
);

	localparam int ADJ_W  = ((SAMPLE_W > CFG_W) ? SAMPLE_W : CFG_W) + 1;
	localparam int PROD_W = ADJ_W + CFG_W;
	localparam int Q_W    = PROD_W - 8;
	localparam int SUM_W  = SAMPLE_W + CNT_W;
	localparam int SM_W   = SAMPLE_W + 8;
	localparam int KP_W   = SM_W + 8;

	localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	logic signed [CFG_W-1:0]    offset_q;
	logic signed [CFG_W-1:0]    scale_q;
	mode_t                      mode_q;
	logic [WIN_LEN_W-1:0]       winlen_q;
	logic [CNT_W-1:0]           win_eff;

	logic signed [SAMPLE_W-1:0] raw_q;
	logic [STAMP_W-1:0]         count_q;
	logic [STAMP_W-1:0]         stamp_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [SAMPLE_W-1:0] v_q;
	logic signed [SAMPLE_W-1:0] res_q;

	logic [SLOT_W-1:0]          slot_q;
	logic [CNT_W-1:0]           fill_q;
	logic signed [SM_W-1:0]     sm_q;

	logic signed [SAMPLE_W-1:0] mem [WINDOW_MAX];
	logic signed [SAMPLE_W-1:0] rdata_s1;
	rd_op_t                     op_s1;

	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SAMPLE_W-1:0] cand_q;
	logic [CNT_W-1:0]           less_q;
	logic [CNT_W-1:0]           eq_q;
	logic [CNT_W-1:0]           med_k;

	logic [SUM_W-1:0]           dq_q;
	logic [CNT_W-1:0]           rem_q;
	logic                       neg_q;
	logic [CNT_W:0]             trial;
	logic                       trial_ge;

	logic signed [ADJ_W-1:0]    adj;
	logic signed [PROD_W-1:0]   prod_c;
	logic signed [Q_W-1:0]      q_c;
	logic signed [SAMPLE_W-1:0] v_c;
	logic signed [KP_W-1:0]     keep_c;
	logic signed [SM_W-1:0]     sm_new;
	logic signed [SAMPLE_W-1:0] lp_out;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_val_q;
	logic [STAMP_W-1:0]         out_stamp_q;

	always_comb begin
		if (winlen_q == '0 || 32'(winlen_q) > 32'(WINDOW_MAX)) begin
			win_eff = CNT_W'(WINDOW_MAX);
		end else begin
			win_eff = CNT_W'(winlen_q);
		end
	end

	assign adj    = ADJ_W'(raw_q) + ADJ_W'(offset_q);
	assign prod_c = PROD_W'(adj) * PROD_W'(scale_q);

	always_comb begin
		q_c = Q_W'(prod_q >>> 8);
		if (prod_q < 0 && prod_q[7:0] != 8'd0) begin
			q_c = q_c + Q_W'(1);
		end
		if (q_c > Q_W'(S_MAX)) begin
			v_c = S_MAX;
		end else if (q_c < Q_W'(S_MIN)) begin
			v_c = S_MIN;
		end else begin
			v_c = SAMPLE_W'(q_c);
		end
	end

	always_comb begin
		keep_c = KP_W'(sm_q) * KP_W'(LP_KEEP);
		sm_new = SM_W'(SM_W'(v_q) * SM_W'(LP_ALPHA)) + SM_W'(keep_c >>> 8);
		lp_out = SAMPLE_W'(sm_new >>> 8);
		if (sm_new < 0 && sm_new[7:0] != 8'd0) begin
			lp_out = lp_out + SAMPLE_W'(1);
		end
	end

	assign med_k    = fill_q >> 1;
	assign trial    = {rem_q, dq_q[SUM_W-1]};
	assign trial_ge = trial >= (CNT_W+1)'(fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= '0;
			scale_q     <= CFG_W'(SCALE_RST);
			mode_q      <= MODE_NONE;
			winlen_q    <= WIN_LEN_W'(WIN_LEN_RST);
			count_q     <= '0;
			slot_q      <= '0;
			fill_q      <= '0;
			sm_q        <= '0;
			op_s1       <= OP_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_OFFSET: offset_q <= cfg_data;
					CFG_SCALE:  scale_q  <= cfg_data;
					CFG_MODE: begin
						mode_q <= mode_t'(cfg_data[1:0]);
						slot_q <= '0;
						fill_q <= '0;
						sm_q   <= '0;
					end
					CFG_WINDOW: begin
						winlen_q <= cfg_data[WIN_LEN_W-1:0];
						slot_q   <= '0;
						fill_q   <= '0;
						sm_q     <= '0;
					end
					default: ;
				endcase
			end else begin
				if (cmd.push) begin
					if (CNT_W'(slot_q) + CNT_W'(1) == win_eff) begin
						slot_q <= '0;
					end else begin
						slot_q <= slot_q + SLOT_W'(1);
					end
					if (fill_q < win_eff) begin
						fill_q <= fill_q + CNT_W'(1);
					end
				end
				if (cmd.lp) begin
					if (fill_q == '0) begin
						sm_q   <= {v_q, 8'd0};
						fill_q <= CNT_W'(1);
					end else begin
						sm_q <= sm_new;
					end
				end
			end
			if (cmd.take) begin
				count_q <= count_q + STAMP_W'(1);
			end
			op_s1 <= cmd.op;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[slot_q] <= v_q;
		end
		rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			raw_q   <= raw_sample;
			stamp_q <= count_q;
		end
		if (cmd.calc) begin
			prod_q <= prod_c;
		end
		if (cmd.sat) begin
			v_q <= v_c;
		end
		if (cmd.pass) begin
			res_q <= v_q;
		end
		if (cmd.lp) begin
			res_q <= (fill_q == '0) ? v_q : lp_out;
		end
		if (cmd.sum_clr) begin
			sum_q <= '0;
		end
		unique case (op_s1)
			OP_SUM: sum_q <= sum_q + SUM_W'(rdata_s1);
			OP_CAND: begin
				cand_q <= rdata_s1;
				less_q <= '0;
				eq_q   <= '0;
			end
			OP_COUNT: begin
				if (rdata_s1 < cand_q) begin
					less_q <= less_q + CNT_W'(1);
				end
				if (rdata_s1 == cand_q) begin
					eq_q <= eq_q + CNT_W'(1);
				end
			end
			OP_CHECK: begin
				if (less_q <= med_k && med_k < less_q + eq_q) begin
					res_q <= cand_q;
				end
			end
			default: ;
		endcase
		if (cmd.div_start) begin
			rem_q <= '0;
			neg_q <= sum_q < 0;
			dq_q  <= (sum_q < 0) ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		end
		if (cmd.div_step) begin
			rem_q <= trial_ge ? CNT_W'(trial - (CNT_W+1)'(fill_q)) : CNT_W'(trial);
			dq_q  <= {dq_q[SUM_W-2:0], trial_ge};
		end
		if (cmd.div_fix) begin
			res_q <= neg_q ? SAMPLE_W'(-dq_q) : SAMPLE_W'(dq_q);
		end
		if (cmd.load_out) begin
			out_val_q   <= res_q;
			out_stamp_q <= stamp_q;
		end
	end

	assign status.mode     = mode_q;
	assign status.out_free = !out_valid_q || !result_stall;
	assign fill            = fill_q;
	assign result_valid    = out_valid_q;
	assign filtered_value  = out_val_q;
	assign sample_stamp    = out_stamp_q;

endmodule

[design/cfs_ctrl.sv]
// ----------------------------------------------------------------------------
// cfs_ctrl
// Sequencer that steps one sample through calibration and the chosen filter.
// ----------------------------------------------------------------------------
module cfs_ctrl import cfs_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_D,
	parameter int SAMPLE_W   = SAMPLE_W_D,
	localparam int SLOT_W    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
	localparam int CNT_W     = $clog2(WINDOW_MAX + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	input  status_t           status,
	input  logic [CNT_W-1:0]  fill,
	output logic              sample_stall,
	output cmd_t              cmd,
	output logic [SLOT_W-1:0] rd_addr
);

	localparam int SUM_W  = SAMPLE_W + CNT_W;
	localparam int DIV_CW = $clog2(SUM_W);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CALC,
		S_SAT,
		S_DISPATCH,
		S_SUM,
		S_DRAIN,
		S_DIVS,
		S_DIV,
		S_FIX,
		S_OUTER,
		S_INNER,
		S_CHECK,
		S_OUT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  j_q;
	logic [DIV_CW-1:0] div_q;
	logic [CNT_W-1:0]  last;

	assign last = fill - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			div_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: state_q <= S_SAT;
				S_SAT:  state_q <= S_DISPATCH;
				S_DISPATCH: begin
					i_q <= '0;
					j_q <= '0;
					unique case (status.mode)
						MODE_AVG: state_q <= S_SUM;
						MODE_MED: state_q <= S_OUTER;
						default:  state_q <= S_OUT;
					endcase
				end
				S_SUM: begin
					j_q <= j_q + CNT_W'(1);
					if (j_q == last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= (status.mode == MODE_AVG) ? S_DIVS : S_OUT;
				end
				S_DIVS: begin
					div_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					div_q <= div_q + DIV_CW'(1);
					if (div_q == DIV_CW'(SUM_W - 1)) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: state_q <= S_OUT;
				S_OUTER: begin
					j_q     <= '0;
					state_q <= S_INNER;
				end
				S_INNER: begin
					j_q <= j_q + CNT_W'(1);
					if (j_q == last) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					i_q     <= i_q + CNT_W'(1);
					state_q <= (i_q == last) ? S_DRAIN : S_OUTER;
				end
				S_OUT: begin
					if (status.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.op      = OP_IDLE;
		rd_addr     = j_q[SLOT_W-1:0];
		unique case (state_q)
			S_IDLE: cmd.take = sample_valid;
			S_CALC: cmd.calc = 1'b1;
			S_SAT:  cmd.sat  = 1'b1;
			S_DISPATCH: begin
				unique case (status.mode)
					MODE_NONE: cmd.pass = 1'b1;
					MODE_LP:   cmd.lp   = 1'b1;
					default: begin
						cmd.push    = 1'b1;
						cmd.sum_clr = 1'b1;
					end
				endcase
			end
			S_SUM:   cmd.op = OP_SUM;
			S_DIVS:  cmd.div_start = 1'b1;
			S_DIV:   cmd.div_step  = 1'b1;
			S_FIX:   cmd.div_fix   = 1'b1;
			S_OUTER: begin
				cmd.op  = OP_CAND;
				rd_addr = i_q[SLOT_W-1:0];
			end
			S_INNER: cmd.op = OP_COUNT;
			S_CHECK: cmd.op = OP_CHECK;
			S_OUT:   cmd.load_out = status.out_free;
			default: ;
		endcase
	end

	assign sample_stall = (state_q != S_IDLE);

endmodule

[design/calibrated_sample_filter_top.sv]
// ----------------------------------------------------------------------------
// calibrated_sample_filter_top
// Calibrates raw samples and filters them by average, median or low-pass.
// ----------------------------------------------------------------------------
// Samples enter on the sample channel (sample_valid, sample_stall, raw_sample)
// and leave on the result channel (result_valid, result_stall, filtered_value,
// sample_stamp); each request in gives exactly one request out. The
// configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; the user must write it only while the block is idle, which the block
// does not enforce; writing the mode or window length restarts filter history.
// One sample is worked on at a time, and the next one is taken while its
// result still waits in the output register.
// The average divides the sum of the n stored samples by n; the divider
// retires one quotient bit a cycle. The median is found through the single
// read port of the window memory, which compares every stored sample with
// every other stored sample, one pair at a time.
// Reset returns the registers to offset 0, unity gain, pass-through and a
// full window, and empties the history and the sample count. When the
// receiver stalls, the result holds, the next sample is still taken and
// worked on, and the one after it waits in stall until the result leaves.
module calibrated_sample_filter_top import cfs_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_D,
	parameter int SAMPLE_W   = SAMPLE_W_D
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [IDX_W-1:0]           cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	input  logic                       sample_valid,
	output logic                       sample_stall,
	input  logic signed [SAMPLE_W-1:0] raw_sample,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [SAMPLE_W-1:0] filtered_value,
	output logic [STAMP_W-1:0]         sample_stamp
);

	localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W  = $clog2(WINDOW_MAX + 1);

	cmd_t              cmd;
	status_t           status;
	logic [CNT_W-1:0]  fill;
	logic [SLOT_W-1:0] rd_addr;

	assign cfg_ready = 1'b1;

	cfs_ctrl #(
		.WINDOW_MAX(WINDOW_MAX),
		.SAMPLE_W  (SAMPLE_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.status      (status),
		.fill        (fill),
		.sample_stall(sample_stall),
		.cmd         (cmd),
		.rd_addr     (rd_addr)
	);

	cfs_datapath #(
		.WINDOW_MAX(WINDOW_MAX),
		.SAMPLE_W  (SAMPLE_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.raw_sample    (raw_sample),
		.cmd           (cmd),
		.rd_addr       (rd_addr),
		.result_stall  (result_stall),
		.status        (status),
		.fill          (fill),
		.result_valid  (result_valid),
		.filtered_value(filtered_value),
		.sample_stamp  (sample_stamp)
	);

endmodule

[design/cfs_checker.sv]
// ----------------------------------------------------------------------------
// cfs_checker
// Port-level checks of the calibrated sample filter, bound to its top level.
// ----------------------------------------------------------------------------
`include "calibrated_sample_filter_top_assert.svh"

module cfs_checker import cfs_pkg::*; #(
	parameter int SAMPLE_W = SAMPLE_W_D
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cfg_ready,
	input logic                       sample_valid,
	input logic                       sample_stall,
	input logic                       result_valid,
	input logic                       result_stall,
	input logic signed [SAMPLE_W-1:0] filtered_value,
	input logic [STAMP_W-1:0]         sample_stamp
);

	`CSF_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid, "result dropped while stalled")
	`CSF_ASSERT_NEXT(a_payload_held, result_valid && result_stall, $stable(filtered_value) && $stable(sample_stamp), "stalled result changed")
	`CSF_ASSERT_NEXT(a_one_at_a_time, sample_valid && !sample_stall, sample_stall, "second request taken while busy")
	`CSF_ASSERT_NEXT(a_no_instant_result, sample_valid && !sample_stall, !$rose(result_valid), "result appeared one cycle after request")
	`CSF_ASSERT(a_cfg_ready, cfg_ready, "configuration channel not ready")

endmodule

bind calibrated_sample_filter_top cfs_checker #(.SAMPLE_W(SAMPLE_W)) u_cfs_checker (.*);
